[rtl/core/brf_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brf_pkg
// shared types and constants of the byte ring fifo with burst requests
// ----------------------------------------------------------------------------
package brf_pkg;

    localparam int BYTE_W   = 8;
    localparam int LEN_W    = 4;
    localparam int SIZE_W   = 9;
    localparam int STAT_W   = 2;
    localparam int NUM_DATA = 8;

    typedef logic [BYTE_W-1:0] t_byte;
    typedef logic [LEN_W-1:0]  t_len;
    typedef logic [SIZE_W-1:0] t_size;
    typedef logic [STAT_W-1:0] t_status;

    // request types
    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_READ  = 1'b1;

    // result status codes
    localparam t_status ST_OK    = 2'd0;
    localparam t_status ST_FULL  = 2'd1;
    localparam t_status ST_EMPTY = 2'd2;

endpackage

[rtl/core/brf_req_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brf_req_if / brf_rsp_if
// valid/ready channels for burst requests and their result beats
// ----------------------------------------------------------------------------
interface brf_req_if
    import brf_pkg::*;
;
    logic  valid;
    logic  ready;
    logic  req_type;
    t_len  length;
    t_byte data_0;
    t_byte data_1;
    t_byte data_2;
    t_byte data_3;
    t_byte data_4;
    t_byte data_5;
    t_byte data_6;
    t_byte data_7;

    modport source (
        output valid, req_type, length,
        output data_0, data_1, data_2, data_3, data_4, data_5, data_6, data_7,
        input  ready
    );
    modport sink (
        input  valid, req_type, length,
        input  data_0, data_1, data_2, data_3, data_4, data_5, data_6, data_7,
        output ready
    );
endinterface

interface brf_rsp_if
    import brf_pkg::*;
;
    logic    valid;
    logic    ready;
    t_status status;
    t_byte   read_byte;
    logic    last;
    t_size   fill_level;
    t_size   free_space;

    modport source (
        output valid, status, read_byte, last, fill_level, free_space,
        input  ready
    );
    modport sink (
        input  valid, status, read_byte, last, fill_level, free_space,
        output ready
    );
endinterface

[rtl/core/brf_store.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brf_store
// single-port byte store, one access per cycle, registered read data
// ----------------------------------------------------------------------------
module brf_store
    import brf_pkg::*;
#(
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  t_byte                    i_wdata,
    output t_byte                    o_rdata
);

    t_byte r_mem [DEPTH];
    t_byte r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                r_mem[i_addr] <= i_wdata;
            end else begin
                r_rdata <= r_mem[i_addr];
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/core/byte_ring_fifo_burst_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// byte_ring_fifo_burst_top
// byte ring fifo with run-time size and all-or-nothing burst requests
// ----------------------------------------------------------------------------
// A request beat asks to write or read 0 to min(MAX_BURST, 8) bytes. A write
// that does not fit in the free space answers full and changes nothing; a read
// of more bytes than are stored answers empty and changes nothing. An accepted
// read returns one result beat per byte, oldest first, with last on the final
// one; every other request returns a single beat with last set. Each result
// carries the fill level and free space as they stand after the whole request.
// Bytes move through a single-port store, one byte per cycle, though a read
// burst is held while the sink stalls and the store output register is full.
// Refusals and zero-length requests go straight to the result state. The
// output register lets a new request be accepted while the last result still
// waits for the sink. Writing the size register (values 0 and above DEPTH are
// clamped to 1 and DEPTH) empties the fifo and holds request ready low for that
// cycle; it must only be written while no request is in progress.
// ----------------------------------------------------------------------------
module byte_ring_fifo_burst_top
    import brf_pkg::*;
#(
    parameter int DEPTH     = 256,
    parameter int MAX_BURST = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    brf_req_if.sink       i_req,
    brf_rsp_if.source     o_rsp,
    input  logic          i_cfg_we,
    input  t_size         i_cfg_data
);

    localparam int AW         = $clog2(DEPTH);
    // wide enough for pointer + 1 and for any size value
    localparam int CW         = ((AW > SIZE_W) ? AW : SIZE_W) + 1;
    localparam int LIMIT      = (MAX_BURST < NUM_DATA) ? MAX_BURST : NUM_DATA;
    localparam int RESET_SIZE = (DEPTH < 256) ? DEPTH : 256;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_WR   = 2'd1;
    localparam logic [1:0] S_RD   = 2'd2;
    localparam logic [1:0] S_RESP = 2'd3;

    // control state
    logic [1:0]    r_state, n_state;
    logic [AW-1:0] r_wr_ptr, n_wr_ptr;
    logic [AW-1:0] r_rd_ptr, n_rd_ptr;
    t_size         r_fill, n_fill;
    t_size         r_size, n_size;
    t_len          r_cnt, n_cnt;
    logic          r_q_valid, n_q_valid;
    logic          r_out_valid, n_out_valid;

    // payload
    t_len          r_len, n_len;
    t_byte         r_data [NUM_DATA];
    t_status       r_status, n_status;
    logic          r_q_last, n_q_last;
    t_status       r_out_status, n_out_status;
    t_byte         r_out_byte, n_out_byte;
    logic          r_out_last, n_out_last;
    t_size         r_out_fill, n_out_fill;
    t_size         r_out_free, n_out_free;

    // store port
    logic          w_mem_en;
    logic          w_mem_we;
    logic [AW-1:0] w_mem_addr;
    t_byte         w_mem_rdata;

    logic          w_accept;
    logic          w_out_free;
    logic          w_move;
    logic          w_issue;
    logic          w_shift;
    t_size         w_free;
    t_size         w_cfg_size;
    logic          w_too_long;

    // pointer step with wrap at the configured size
    function automatic logic [AW-1:0] f_next(input logic [AW-1:0] p, input t_size sz);
        logic [CW-1:0] n;
        n = CW'(p) + CW'(1);
        return (n >= CW'(sz)) ? '0 : n[AW-1:0];
    endfunction

    brf_store #(
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_en    (w_mem_en),
        .i_we    (w_mem_we),
        .i_addr  (w_mem_addr),
        .i_wdata (r_data[0]),
        .o_rdata (w_mem_rdata)
    );

    // no request is taken in the cycle the size register is written
    assign i_req.ready = (r_state == S_IDLE) && !i_cfg_we;
    assign w_accept    = i_req.valid && i_req.ready;
    assign w_out_free  = !r_out_valid || o_rsp.ready;
    assign w_move      = r_q_valid && w_out_free;
    assign w_free      = r_size - r_fill;
    assign w_too_long  = (i_req.length > LEN_W'(LIMIT));

    // read issue: only when the store output register can be handed on
    assign w_issue = (r_state == S_RD) && (r_cnt != r_len) && (!r_q_valid || w_move);
    assign w_shift = (r_state == S_WR);

    assign w_mem_en   = w_shift || w_issue;
    assign w_mem_we   = w_shift;
    assign w_mem_addr = w_shift ? r_wr_ptr : r_rd_ptr;

    // size register clamp
    always_comb begin
        w_cfg_size = i_cfg_data;
        if (i_cfg_data == '0) begin
            w_cfg_size = t_size'(1);
        end else if (CW'(i_cfg_data) > CW'(DEPTH)) begin
            w_cfg_size = t_size'(DEPTH);
        end
    end

    always_comb begin
        n_state      = r_state;
        n_wr_ptr     = r_wr_ptr;
        n_rd_ptr     = r_rd_ptr;
        n_fill       = r_fill;
        n_size       = r_size;
        n_cnt        = r_cnt;
        n_len        = r_len;
        n_status     = r_status;
        n_q_valid    = r_q_valid;
        n_q_last     = r_q_last;
        n_out_valid  = r_out_valid;
        n_out_status = r_out_status;
        n_out_byte   = r_out_byte;
        n_out_last   = r_out_last;
        n_out_fill   = r_out_fill;
        n_out_free   = r_out_free;

        // result register drains independently of the request side
        if (r_out_valid && o_rsp.ready) begin
            n_out_valid = 1'b0;
        end

        // read byte from the store into the result register
        if (w_move) begin
            n_out_valid  = 1'b1;
            n_out_status = ST_OK;
            n_out_byte   = w_mem_rdata;
            n_out_last   = r_q_last;
            n_out_fill   = r_fill;
            n_out_free   = w_free;
            n_q_valid    = 1'b0;
        end
        if (w_issue) begin
            n_q_valid = 1'b1;
            n_q_last  = (r_cnt + t_len'(1) == r_len);
            n_rd_ptr  = f_next(r_rd_ptr, r_size);
            n_cnt     = r_cnt + t_len'(1);
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_cfg_we) begin
                    n_size   = w_cfg_size;
                    n_wr_ptr = '0;
                    n_rd_ptr = '0;
                    n_fill   = '0;
                end else if (w_accept) begin
                    n_len   = i_req.length;
                    n_cnt   = '0;
                    n_state = S_RESP;
                    if (i_req.length == '0) begin
                        n_status = ST_OK;
                    end else if (i_req.req_type == REQ_WRITE) begin
                        if (w_too_long || (t_size'(i_req.length) > w_free)) begin
                            n_status = ST_FULL;
                        end else begin
                            n_status = ST_OK;
                            n_fill   = r_fill + t_size'(i_req.length);
                            n_state  = S_WR;
                        end
                    end else begin
                        if (w_too_long || (t_size'(i_req.length) > r_fill)) begin
                            n_status = ST_EMPTY;
                        end else begin
                            n_fill  = r_fill - t_size'(i_req.length);
                            n_state = S_RD;
                        end
                    end
                end
            end
            S_WR: begin
                n_wr_ptr = f_next(r_wr_ptr, r_size);
                n_cnt    = r_cnt + t_len'(1);
                if (r_cnt == r_len - t_len'(1)) begin
                    n_state = S_RESP;
                end
            end
            S_RD: begin
                if ((r_cnt == r_len) && !r_q_valid) begin
                    n_state = S_IDLE;
                end
            end
            S_RESP: begin
                if (w_out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_status;
                    n_out_byte   = '0;
                    n_out_last   = 1'b1;
                    n_out_fill   = r_fill;
                    n_out_free   = w_free;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_wr_ptr    <= '0;
            r_rd_ptr    <= '0;
            r_fill      <= '0;
            r_size      <= t_size'(RESET_SIZE);
            r_cnt       <= '0;
            r_q_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_wr_ptr    <= n_wr_ptr;
            r_rd_ptr    <= n_rd_ptr;
            r_fill      <= n_fill;
            r_size      <= n_size;
            r_cnt       <= n_cnt;
            r_q_valid   <= n_q_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        r_len        <= n_len;
        r_status     <= n_status;
        r_q_last     <= n_q_last;
        r_out_status <= n_out_status;
        r_out_byte   <= n_out_byte;
        r_out_last   <= n_out_last;
        r_out_fill   <= n_out_fill;
        r_out_free   <= n_out_free;
        if (w_accept) begin
            r_data[0] <= i_req.data_0;
            r_data[1] <= i_req.data_1;
            r_data[2] <= i_req.data_2;
            r_data[3] <= i_req.data_3;
            r_data[4] <= i_req.data_4;
            r_data[5] <= i_req.data_5;
            r_data[6] <= i_req.data_6;
            r_data[7] <= i_req.data_7;
        end else if (w_shift) begin
            // next byte to write always sits in slot 0
            for (int i = 0; i < NUM_DATA - 1; i++) begin
                r_data[i] <= r_data[i+1];
            end
        end
    end

    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.status     = r_out_status;
    assign o_rsp.read_byte  = r_out_byte;
    assign o_rsp.last       = r_out_last;
    assign o_rsp.fill_level = r_out_fill;
    assign o_rsp.free_space = r_out_free;

    // fill level never passes the configured size
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= r_size)
        else $error("fill level above fifo size");

    // store read data is only outstanding during a read burst
    a_q_in_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_q_valid |-> (r_state == S_RD))
        else $error("store read data outstanding outside read burst");

    // an accepted request always leaves idle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && !i_cfg_we) |=> (r_state != S_IDLE))
        else $error("request accepted without leaving idle");

endmodule
